[hw/rtl/assert_macros.svh]
// Concurrent assertion helpers used by the detector RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define TMCD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the usual clock and reset port names.
`define TMCD_ASSERT(lbl, prop, msg) \
  `TMCD_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[hw/rtl/tmcd_pkg.sv]
// ----------------------------------------------------------------------------
// TCP mid-stream connection detector package
// Types and constants shared by the detector and its word interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package tmcd_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned AGE_W  = 16;

  localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 16'd60;

  typedef enum logic [2:0] {
    ST_IGNORED  = 3'd0,
    ST_CLOSED   = 3'd1,
    ST_STORED   = 3'd2,
    ST_REPLACED = 3'd3,
    ST_CONNECT  = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [ADDR_W-1:0] dst_addr;
    logic [PORT_W-1:0] src_port;
    logic [PORT_W-1:0] dst_port;
    logic              flag_syn;
    logic              flag_ece;
    logic              flag_fin;
    logic              flag_rst;
    logic [TIME_W-1:0] time_seconds;
  } in_word_t;

  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] client_addr;
    logic [PORT_W-1:0] client_port;
    logic [ADDR_W-1:0] server_addr;
    logic [PORT_W-1:0] server_port;
  } out_word_t;

endpackage

`default_nettype wire

[hw/rtl/tmcd_in_if.sv]
// ----------------------------------------------------------------------------
// Packet header channel
// Valid/ready channel that carries one TCP packet header per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmcd_in_if import tmcd_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] src_addr;
  logic [ADDR_W-1:0] dst_addr;
  logic [PORT_W-1:0] src_port;
  logic [PORT_W-1:0] dst_port;
  logic              flag_syn;
  logic              flag_ece;
  logic              flag_fin;
  logic              flag_rst;
  logic [TIME_W-1:0] time_seconds;

  modport source (
    output valid, src_addr, dst_addr, src_port, dst_port,
    output flag_syn, flag_ece, flag_fin, flag_rst, time_seconds,
    input  ready
  );

  modport sink (
    input  valid, src_addr, dst_addr, src_port, dst_port,
    input  flag_syn, flag_ece, flag_fin, flag_rst, time_seconds,
    output ready
  );

endinterface

`default_nettype wire

[hw/rtl/tmcd_out_if.sv]
// ----------------------------------------------------------------------------
// Detection result channel
// Valid/ready channel that carries one detection result per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmcd_out_if import tmcd_pkg::*; ();

  logic              valid;
  logic              ready;
  status_e           status;
  logic [ADDR_W-1:0] client_addr;
  logic [PORT_W-1:0] client_port;
  logic [ADDR_W-1:0] server_addr;
  logic [PORT_W-1:0] server_port;

  modport source (
    output valid, status, client_addr, client_port, server_addr, server_port,
    input  ready
  );

  modport sink (
    input  valid, status, client_addr, client_port, server_addr, server_port,
    output ready
  );

endinterface

`default_nettype wire

[hw/rtl/tcp_midstream_connection_detector.sv]
// A header word is registered in the input register, looked up, and its result registered in the result register.
// Throughput: one header word per cycle when no result word stalls; the table is searched in parallel.
// A stalled result word holds the pipeline, and the input register is free again once it moves.
// Reset clears all table valid bits at once and sets the age limit to 60 seconds.
// ----------------------------------------------------------------------------
// TCP mid-stream connection detector
// Fully associative table of pending packets keyed by the unordered address
// and port pair; a reverse-direction packet within the age limit reports a
// connection.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module tcp_midstream_connection_detector import tmcd_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AGE_W-1:0] cfg_wdata_i,
  tmcd_in_if.sink          in_i,
  tmcd_out_if.source       out_o
);

  logic [AGE_W-1:0] age_q;

  logic     in_valid_q;
  in_word_t in_q;
  logic     in_accept;
  logic     fire;

  logic      out_valid_q;
  out_word_t out_q;
  out_word_t res_d;

  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [TABLE_ENTRIES-1:0] valid_d;
  logic [ADDR_W-1:0] ent_src_addr_q [TABLE_ENTRIES];
  logic [ADDR_W-1:0] ent_dst_addr_q [TABLE_ENTRIES];
  logic [PORT_W-1:0] ent_src_port_q [TABLE_ENTRIES];
  logic [PORT_W-1:0] ent_dst_port_q [TABLE_ENTRIES];
  logic [TIME_W-1:0] ent_time_q     [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] match;
  logic [TABLE_ENTRIES-1:0] free;
  logic [TABLE_ENTRIES-1:0] hit_oh;
  logic [TABLE_ENTRIES-1:0] free_oh;
  logic [TABLE_ENTRIES-1:0] wr_oh;
  logic [TABLE_ENTRIES-1:0] clr_oh;

  logic [ADDR_W-1:0] sel_src_addr;
  logic [ADDR_W-1:0] sel_dst_addr;
  logic [PORT_W-1:0] sel_src_port;
  logic [PORT_W-1:0] sel_dst_port;
  logic [TIME_W-1:0] sel_time;
  logic [TIME_W-1:0] diff;
  logic              young;
  logic              reverse;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= AGE_LIMIT_RESET;
    end else if (cfg_we_i) begin
      age_q <= cfg_wdata_i;
    end
  end

  // Input register.
  assign fire      = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;
  assign in_accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q.src_addr     <= in_i.src_addr;
      in_q.dst_addr     <= in_i.dst_addr;
      in_q.src_port     <= in_i.src_port;
      in_q.dst_port     <= in_i.dst_port;
      in_q.flag_syn     <= in_i.flag_syn;
      in_q.flag_ece     <= in_i.flag_ece;
      in_q.flag_fin     <= in_i.flag_fin;
      in_q.flag_rst     <= in_i.flag_rst;
      in_q.time_seconds <= in_i.time_seconds;
    end
  end

  // Parallel compare of every entry against both directions of the word.
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = valid_q[i] &&
                 ((ent_src_addr_q[i] == in_q.src_addr && ent_dst_addr_q[i] == in_q.dst_addr &&
                   ent_src_port_q[i] == in_q.src_port && ent_dst_port_q[i] == in_q.dst_port) ||
                  (ent_src_addr_q[i] == in_q.dst_addr && ent_dst_addr_q[i] == in_q.src_addr &&
                   ent_src_port_q[i] == in_q.dst_port && ent_dst_port_q[i] == in_q.src_port));
    end
  end

  assign free    = ~valid_q;
  assign hit_oh  = match & (~match + 1'b1);
  assign free_oh = free & (~free + 1'b1);

  always_comb begin
    sel_src_addr = '0;
    sel_dst_addr = '0;
    sel_src_port = '0;
    sel_dst_port = '0;
    sel_time     = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit_oh[i]) begin
        sel_src_addr = sel_src_addr | ent_src_addr_q[i];
        sel_dst_addr = sel_dst_addr | ent_dst_addr_q[i];
        sel_src_port = sel_src_port | ent_src_port_q[i];
        sel_dst_port = sel_dst_port | ent_dst_port_q[i];
        sel_time     = sel_time | ent_time_q[i];
      end
    end
  end

  // The time difference is signed, so a negative difference is always young.
  assign diff    = in_q.time_seconds - sel_time;
  assign young   = $signed({diff[TIME_W-1], diff}) <
                   $signed({{(TIME_W + 1 - AGE_W){1'b0}}, age_q});
  assign reverse = sel_src_addr == in_q.dst_addr && sel_src_port == in_q.dst_port && young;

  always_comb begin
    res_d  = '0;
    wr_oh  = '0;
    clr_oh = '0;
    if (in_q.flag_syn || in_q.flag_ece) begin
      res_d.status = ST_IGNORED;
    end else if (in_q.flag_fin || in_q.flag_rst) begin
      res_d.status = ST_CLOSED;
      clr_oh       = hit_oh;
    end else if (!(|match)) begin
      if (|free) begin
        res_d.status = ST_STORED;
        wr_oh        = free_oh;
      end else begin
        res_d.status = ST_FULL;
      end
    end else if (reverse) begin
      res_d.status = ST_CONNECT;
      clr_oh       = hit_oh;
      if (in_q.src_port > in_q.dst_port) begin
        res_d.client_addr = in_q.src_addr;
        res_d.client_port = in_q.src_port;
        res_d.server_addr = in_q.dst_addr;
        res_d.server_port = in_q.dst_port;
      end else begin
        res_d.client_addr = sel_src_addr;
        res_d.client_port = sel_src_port;
        res_d.server_addr = sel_dst_addr;
        res_d.server_port = sel_dst_port;
      end
    end else begin
      res_d.status = ST_REPLACED;
      wr_oh        = hit_oh;
    end
  end

  // Table update.
  assign valid_d = fire ? ((valid_q & ~clr_oh) | wr_oh) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (fire && wr_oh[i]) begin
        ent_src_addr_q[i] <= in_q.src_addr;
        ent_dst_addr_q[i] <= in_q.dst_addr;
        ent_src_port_q[i] <= in_q.src_port;
        ent_dst_port_q[i] <= in_q.dst_port;
        ent_time_q[i]     <= in_q.time_seconds;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_q.status;
  assign out_o.client_addr = out_q.client_addr;
  assign out_o.client_port = out_q.client_port;
  assign out_o.server_addr = out_q.server_addr;
  assign out_o.server_port = out_q.server_port;

  `TMCD_ASSERT(a_store_adds_entry,
    fire && res_d.status == ST_STORED |=> $countones(valid_q) == $past($countones(valid_q)) + 1,
    "A stored word did not occupy exactly one new entry.")
  `TMCD_ASSERT(a_full_only_when_full,
    fire && res_d.status == ST_FULL |-> &valid_q,
    "Table full reported while an entry was free.")
  `TMCD_ASSERT(a_fields_zero,
    out_valid_q && out_q.status != ST_CONNECT |->
      out_q.client_addr == '0 && out_q.client_port == '0 &&
      out_q.server_addr == '0 && out_q.server_port == '0,
    "Connection fields are nonzero on a word that reports no connection.")
  `TMCD_ASSERT(a_stall_cause,
    !in_i.ready |-> in_valid_q && out_valid_q && !out_o.ready,
    "Input stalled without a stalled result word.")
  `TMCD_ASSERT(a_single_write,
    fire |-> $onehot0(wr_oh | clr_oh),
    "More than one table entry is updated by one word.")

endmodule

`default_nettype wire
